### rtl/core/dabfc_pkg.sv
// Shared types, constants and the fire code byte update for the DAB+ fire code checker.
package dabfc_pkg;

    localparam int BLOCK_BYTES_DEF = 11;
    localparam int POS_W           = 4;
    localparam int REM_W           = 16;

    localparam logic [REM_W-1:0] FIRE_POLY = 16'h782F;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       frame_start;
    } t_in;

    typedef struct packed {
        logic             frame_ok;
        logic [REM_W-1:0] syndrome;
    } t_out;

    // Shifts one byte into the remainder, most significant bit first.
    function automatic logic [REM_W-1:0] fire_shift_byte(
        input logic [REM_W-1:0] rem,
        input logic [7:0]       data
    );
        logic [REM_W-1:0] t;
        logic             msb;
        t = {rem[15:8], 8'h00};
        for (int k = 0; k < 8; k++) begin
            msb = t[15];
            t   = {t[14:0], 1'b0};
            if (msb) begin
                t = t ^ FIRE_POLY;
            end
        end
        return t ^ {rem[7:0], data};
    endfunction

endpackage

### rtl/core/dab_plus_fire_code_checker_core.sv
// Top level of the DAB+ superframe fire code checker.
//
// The input channel carries one byte of the checked block per transaction,
// with a flag that marks the first byte of a block. A block has BLOCK_BYTES
// bytes: two check word bytes, two seed bytes, then the payload bytes.
// After the last byte of a block, one transaction leaves on the output
// channel with the final remainder and a pass flag that is set when the
// remainder is zero. Bytes that arrive outside a block are dropped.
// Each accepted byte goes to an input register; when it advances, the
// byte update and, for the last byte, the two check word updates run in one
// pass of XOR logic into the remainder and, for the last byte, the result
// register, which drives o_valid. One byte is taken in
// every cycle while the output is not blocked.
// When the receiver stalls a pending result, the input register keeps its
// byte and o_stall rises, so no transaction is lost or reordered.
// Synchronous reset clears the valid flags of both registers, the remainder and the held check
// word, and leaves the block idle until a byte with the start flag comes.
module dab_plus_fire_code_checker_core #(
    parameter int BLOCK_BYTES = dabfc_pkg::BLOCK_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  dabfc_pkg::t_in  i_data,
    output logic            o_stall,
    output logic            o_valid,
    output dabfc_pkg::t_out o_data,
    input  logic            i_stall
);
    import dabfc_pkg::*;

    localparam logic [POS_W-1:0] POS_CHECK_HI = POS_W'(0);
    localparam logic [POS_W-1:0] POS_CHECK_LO = POS_W'(1);
    localparam logic [POS_W-1:0] POS_SEED_HI  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_SEED_LO  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_LAST     = POS_W'(BLOCK_BYTES - 1);
    localparam logic [POS_W-1:0] POS_IDLE     = POS_W'(BLOCK_BYTES);

    logic             r_in_vld;
    t_in              r_in;
    logic [POS_W-1:0] r_pos,  n_pos;
    logic [REM_W-1:0] r_rem,  n_rem;
    logic [REM_W-1:0] r_held, n_held;
    logic             r_out_vld;
    t_out             r_out;

    logic             advance;
    logic             emit;
    logic [POS_W-1:0] pos;
    logic [REM_W-1:0] rem_byte;
    logic [REM_W-1:0] rem_final;

    assign advance = r_in_vld && !(r_out_vld && i_stall);
    assign o_stall = r_in_vld && !advance;

    always_comb begin
        pos       = r_in.frame_start ? POS_CHECK_HI : r_pos;
        n_held    = r_held;
        rem_byte  = r_rem;
        emit      = 1'b0;
        n_pos     = pos;
        if (pos < POS_IDLE) begin
            case (pos)
                POS_CHECK_HI: n_held   = {r_in.byte_value, r_held[7:0]};
                POS_CHECK_LO: n_held   = {r_held[15:8], r_in.byte_value};
                POS_SEED_HI:  rem_byte = {r_in.byte_value, 8'h00};
                POS_SEED_LO:  rem_byte = {r_rem[15:8], r_in.byte_value};
                default:      rem_byte = fire_shift_byte(r_rem, r_in.byte_value);
            endcase
            n_pos = pos + POS_W'(1);
            emit  = (pos == POS_LAST);
        end
        rem_final = fire_shift_byte(fire_shift_byte(rem_byte, r_held[15:8]), r_held[7:0]);
        n_rem     = emit ? rem_final : rem_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_pos     <= POS_IDLE;
            r_rem     <= '0;
            r_held    <= '0;
        end else begin
            if (i_valid && !o_stall) begin
                r_in_vld <= 1'b1;
                r_in     <= i_data;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_pos  <= n_pos;
                r_rem  <= n_rem;
                r_held <= n_held;
            end
            if (advance && emit) begin
                r_out_vld      <= 1'b1;
                r_out.syndrome <= rem_final;
                r_out.frame_ok <= (rem_final == '0);
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

### rtl/core/dabfc_checker.sv
// Port-level assertions for the fire code checker, bound to its top level.
module dabfc_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input dabfc_pkg::t_in  i_data,
    input logic            o_stall,
    input logic            o_valid,
    input dabfc_pkg::t_out o_data,
    input logic            i_stall
);
    import dabfc_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("Stalled result was withdrawn.");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_data))
        else $error("Stalled result changed.");

    a_pass_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.frame_ok == (o_data.syndrome == '0)))
        else $error("Pass flag disagrees with the syndrome.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("Block not idle after reset.");

endmodule

bind dab_plus_fire_code_checker_core dabfc_checker u_dabfc_checker (.*);

### verif/testbench.sv
// Self-checking testbench for the DAB+ fire code checker core.
`timescale 1ns / 1ps

module testbench;

    localparam int NBYTES       = dabfc_pkg::BLOCK_BYTES_DEF;
    localparam int ITEMS        = 1450;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 6;
    localparam int LIMIT_CYCLES = 800000;

    class fire_code_book;
        logic [15:0]     held_word;
        logic [15:0]     rem;
        int unsigned     position;
        int unsigned     counted;
        int unsigned     errors;
        dabfc_pkg::t_out expected_q[$];

        function new();
            held_word = '0;
            rem       = '0;
            position  = NBYTES;
            counted   = 0;
            errors    = 0;
        endfunction

        static function logic [15:0] divide_byte(logic [15:0] r, logic [7:0] b);
            logic [15:0] acc;
            acc = {r[15:8], 8'h00};
            for (int k = 0; k < 8; k++) begin
                if (acc[15]) begin
                    acc = {acc[14:0], 1'b0} ^ dabfc_pkg::FIRE_POLY;
                end else begin
                    acc = {acc[14:0], 1'b0};
                end
            end
            return acc ^ {r[7:0], b};
        endfunction

        function void note_byte(logic [7:0] b, logic s);
            dabfc_pkg::t_out res;
            if (s) begin
                position = 0;
            end
            if (position >= NBYTES) begin
                return;
            end
            counted++;
            case (position)
                0: begin
                    held_word[15:8] = b;
                end
                1: begin
                    held_word[7:0] = b;
                end
                2: begin
                    rem = {b, 8'h00};
                end
                3: begin
                    rem[7:0] = b;
                end
                default: begin
                    rem = divide_byte(rem, b);
                end
            endcase
            position++;
            if (position == NBYTES) begin
                rem = divide_byte(rem, held_word[15:8]);
                rem = divide_byte(rem, held_word[7:0]);
                res.frame_ok = (rem == 16'h0000);
                res.syndrome = rem;
                expected_q.push_back(res);
            end
        endfunction

        function void check_result(dabfc_pkg::t_out got);
            dabfc_pkg::t_out want;
            if (expected_q.size() == 0) begin
                $error("unexpected transaction: frame_ok %0b syndrome %h",
                       got.frame_ok, got.syndrome);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.frame_ok !== want.frame_ok) begin
                $error("frame_ok: expected %0b, actual %0b", want.frame_ok, got.frame_ok);
                errors++;
            end
            if (got.syndrome !== want.syndrome) begin
                $error("syndrome: expected %h, actual %h", want.syndrome, got.syndrome);
                errors++;
            end
        endfunction
    endclass

    logic            i_clk;
    logic            i_rst_n;
    logic            i_valid;
    dabfc_pkg::t_in  i_data;
    logic            o_stall;
    logic            o_valid;
    dabfc_pkg::t_out o_data;
    logic            i_stall;

    fire_code_book book = new();
    logic [7:0]    frame_bytes[NBYTES];
    bit            hold_off_req = 1'b0;
    int unsigned   cycles = 0;

    dab_plus_fire_code_checker_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            book.check_result(o_data);
        end
    end

    initial begin : receiver
        int mode;
        int span;
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                mode = $urandom_range(0, 99);
                if (mode < 50) begin
                    i_stall <= 1'b0;
                    span = $urandom_range(1, 8);
                end else if (mode < 85) begin
                    i_stall <= 1'b1;
                    span = $urandom_range(1, 3);
                end else if (mode < 95) begin
                    i_stall <= 1'b1;
                    span = $urandom_range(4, 40);
                end else begin
                    i_stall <= 1'b0;
                    span = $urandom_range(50, 150);
                end
                repeat (span) @(posedge i_clk);
            end
        end
    end

    function automatic int pick_gap(bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic s, input bit burst);
        int gap;
        gap = pick_gap(burst);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{byte_value: b, frame_start: s};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        book.note_byte(b, s);
    endtask

    task automatic send_frame(input int len, input bit burst);
        for (int k = 0; k < len; k++) begin
            send_byte(frame_bytes[k], k == 0, burst);
        end
    endtask

    // Chooses the two check word bytes so that the final remainder is zero.
    function automatic void set_check_word();
        logic [15:0] r;
        logic [15:0] f_first;
        logic [15:0] f_second;
        r = {frame_bytes[2], frame_bytes[3]};
        for (int k = 4; k < NBYTES; k++) begin
            r = fire_code_book::divide_byte(r, frame_bytes[k]);
        end
        f_first  = fire_code_book::divide_byte({r[15:8], 8'h00}, 8'h00);
        f_second = fire_code_book::divide_byte({f_first[15:8] ^ r[7:0], 8'h00}, 8'h00);
        frame_bytes[0] = f_first[7:0] ^ f_second[15:8];
        frame_bytes[1] = f_second[7:0];
    endfunction

    task automatic fill_frame(input logic [7:0] fixed, input bit random_content);
        for (int k = 0; k < NBYTES; k++) begin
            frame_bytes[k] = random_content ? 8'($urandom_range(0, 255)) : fixed;
        end
    endtask

    task automatic settle_output();
        i_valid <= 1'b0;
        while (book.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int kind;
        int frames;
        int spot;
        bit burst;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_byte(8'hFF, 1'b0, 1'b0);
        fill_frame(8'h00, 1'b0);
        send_frame(NBYTES, 1'b1);
        fill_frame(8'hFF, 1'b0);
        send_frame(3, 1'b0);
        set_check_word();
        send_frame(NBYTES, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        settle_output();

        frames = 0;
        while (book.counted < ITEMS) begin
            frames++;
            if (frames == 15 || frames == 90) begin
                hold_off_req = 1'b1;
            end
            if (frames == 40 || frames == 120) begin
                settle_output();
            end
            kind  = $urandom_range(0, 99);
            burst = ($urandom_range(0, 3) == 0);
            fill_frame(8'h00, 1'b1);
            if (kind < 55) begin
                set_check_word();
                if (kind >= 45) begin
                    spot = $urandom_range(0, NBYTES - 1);
                    frame_bytes[spot][$urandom_range(0, 7)] ^= 1'b1;
                end
                send_frame(NBYTES, burst);
            end else if (kind < 85) begin
                send_frame(NBYTES, burst);
            end else if (kind < 93) begin
                send_frame($urandom_range(1, NBYTES - 1), burst);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_byte(8'($urandom_range(0, 255)), 1'b0, burst);
                end
            end
        end

        settle_output();
        if (book.errors == 0 && book.expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/dabfc_pkg.sv
rtl/core/dab_plus_fire_code_checker_core.sv
rtl/core/dabfc_checker.sv
verif/testbench.sv
